// ----- design/multiset_max_xor_query_core_macros.svh -----
// Assertion macros shared by the multiset max-XOR query core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MULTISET_MAX_XOR_QUERY_CORE_MACROS_SVH
`define MULTISET_MAX_XOR_QUERY_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MMXQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMXQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mmxq_pkg.sv -----
// Shared types and constants for the multiset max-XOR query core.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package mmxq_pkg;

   localparam int COUNT_W = 24;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

   // Operation codes carried by an input word.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // Status codes returned with each result word.
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_ABSENT = 2'd2
   } stat_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ROOT,
      S_WALK,
      S_FETCH,
      S_FINISH
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic root;
      logic walk;
      logic fetch;
      logic pass2;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       stop;
      logic       fail;
      logic [1:0] op;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- design/mmxq_datapath.sv -----
// Datapath of the multiset max-XOR query core: trie link and count memories,
// walk registers, node allocator and result registers. Depends on mmxq_pkg.
`default_nettype none

module mmxq_datapath
   import mmxq_pkg::*;
#(
   parameter int KEY_BITS  = 32,
   parameter int NODE_POOL = 65536,
   parameter int IW        = 16,
   parameter int NW        = 17,
   parameter int LW        = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire logic [LW-1:0]     lvl,
   input  wire logic [1:0]        req_operation,
   input  wire logic [31:0]       req_key,
   output dp_stat_type            st,
   output logic [31:0]            rsp_max_xor,
   output logic [1:0]             rsp_status
);

   localparam int LB = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

   // Trie storage: one entry per node holds both child links.
   logic [1:0][IW-1:0]    link_mem [NODE_POOL];
   logic [COUNT_W-1:0]    cnt_mem  [NODE_POOL];

   logic [1:0][1:0][IW-1:0]    rd_link_ff;
   logic [1:0][COUNT_W-1:0]    rd_cnt_ff;

   logic [1:0][IW-1:0]  curl_ff, curl_in;
   logic [IW-1:0]       node_ff, node_in;
   logic [NW-1:0]       nf_ff, nf_in;
   logic                fresh_ff, fresh_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] res_ff, res_in;
   logic [1:0]          status_ff, status_in;
   logic [LW-1:0]       missing_ff, missing_in;
   logic [31:0]         rsp_max_xor_ff, rsp_max_xor_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                link_we, cnt_we;
   logic [IW-1:0]       link_wa, cnt_wa;
   logic [1:0][IW-1:0]  link_wd;
   logic [COUNT_W-1:0]  cnt_wd;

   logic                bsel;
   logic [IW-1:0]       c_same, c_opp;
   logic [COUNT_W-1:0]  n_same, n_opp;
   logic                pool_short;
   logic                stop;

   // Child on the key's side and on the opposite side of the current node.
   assign bsel   = key_ff[lvl[LB-1:0]];
   assign c_same = curl_ff[bsel];
   assign c_opp  = curl_ff[~bsel];
   assign n_same = rd_cnt_ff[bsel];
   assign n_opp  = rd_cnt_ff[~bsel];

   // An add needs missing new nodes; the pool must still hold them.
   assign pool_short = ({1'b0, nf_ff} + (NW+1)'(missing_ff)) > (NW+1)'(NODE_POOL);

   // Walk decisions, memory writes and register updates.
   always_comb begin
      curl_in        = '0;
      node_in        = node_ff;
      nf_in          = nf_ff;
      fresh_in       = fresh_ff;
      key_in         = key_ff;
      op_in          = op_ff;
      res_in         = res_ff;
      status_in      = status_ff;
      missing_in     = missing_ff;
      rsp_max_xor_in = rsp_max_xor_ff;
      rsp_status_in  = rsp_status_ff;
      link_we        = 1'b0;
      link_wa        = node_ff;
      link_wd        = curl_ff;
      cnt_we         = 1'b0;
      cnt_wa         = c_same;
      cnt_wd         = n_same;
      stop           = 1'b0;

      if (cmd.clear) begin
         // Build the permanent zero path, one node a cycle.
         link_we    = 1'b1;
         link_wa    = IW'(lvl);
         link_wd    = '0;
         if (lvl < LW'(KEY_BITS)) begin
            link_wd[0] = IW'(lvl) + IW'(1);
         end
         cnt_we     = 1'b1;
         cnt_wa     = IW'(lvl);
         cnt_wd     = (lvl == '0) ? '0 : COUNT_W'(1);
      end

      if (cmd.capture) begin
         key_in     = req_key[KEY_BITS-1:0];
         op_in      = req_operation;
         res_in     = '0;
         status_in  = STAT_OK;
         missing_in = '0;
         fresh_in   = 1'b0;
      end

      if (cmd.root) begin
         curl_in = rd_link_ff[0];
         node_in = '0;
      end

      if (cmd.fetch) begin
         fresh_in = 1'b0;
         if (op_ff == OP_ADD && pool_short) begin
            status_in = STAT_FULL;
         end
      end

      if (cmd.walk) begin
         case (op_ff)
            OP_ADD: begin
               if (!cmd.pass2) begin
                  // Check pass: find where the path ends and look for full counts.
                  if (c_same == '0) begin
                     missing_in = lvl + LW'(1);
                     stop       = 1'b1;
                  end else if (n_same == COUNT_MAX) begin
                     status_in = STAT_FULL;
                     stop      = 1'b1;
                  end else begin
                     node_in = c_same;
                     curl_in = rd_link_ff[bsel];
                  end
               end else if (fresh_ff || c_same == '0) begin
                  // Allocate a new node and link it below the current one.
                  link_we       = 1'b1;
                  link_wd[bsel] = nf_ff[IW-1:0];
                  cnt_we        = 1'b1;
                  cnt_wa        = nf_ff[IW-1:0];
                  cnt_wd        = COUNT_W'(1);
                  nf_in         = nf_ff + NW'(1);
                  fresh_in      = 1'b1;
                  node_in       = nf_ff[IW-1:0];
               end else begin
                  cnt_we  = 1'b1;
                  cnt_wd  = n_same + COUNT_W'(1);
                  node_in = c_same;
                  curl_in = rd_link_ff[bsel];
               end
            end
            OP_REMOVE: begin
               if (!cmd.pass2) begin
                  // Check pass: every node must be present, and the permanent
                  // zero needs a second copy before it can be removed.
                  if (c_same == '0 || n_same == '0 ||
                      (lvl == '0 && key_ff == '0 && n_same < COUNT_W'(2))) begin
                     status_in = STAT_ABSENT;
                     stop      = 1'b1;
                  end else begin
                     node_in = c_same;
                     curl_in = rd_link_ff[bsel];
                  end
               end else begin
                  cnt_we  = 1'b1;
                  cnt_wd  = n_same - COUNT_W'(1);
                  node_in = c_same;
                  curl_in = rd_link_ff[bsel];
               end
            end
            OP_QUERY: begin
               // Prefer the opposite bit when that child is present.
               if (c_opp != '0 && n_opp != '0) begin
                  res_in[lvl[LB-1:0]] = 1'b1;
                  node_in = c_opp;
                  curl_in = rd_link_ff[~bsel];
               end else if (c_same != '0 && n_same != '0) begin
                  node_in = c_same;
                  curl_in = rd_link_ff[bsel];
               end else begin
                  stop = 1'b1;
               end
            end
            default: begin
               stop = 1'b1;
            end
         endcase
      end

      if (cmd.load_rsp) begin
         rsp_max_xor_in = 32'(res_ff);
         rsp_status_in  = status_ff;
      end
   end

   // Memory ports: one write and two registered reads per memory.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      rd_link_ff[0] <= link_mem[curl_in[0]];
      rd_link_ff[1] <= link_mem[curl_in[1]];
      rd_cnt_ff[0]  <= cnt_mem[curl_in[0]];
      rd_cnt_ff[1]  <= cnt_mem[curl_in[1]];
   end

   // Walk and result registers.
   always_ff @(posedge clock) begin
      curl_ff        <= curl_in;
      node_ff        <= node_in;
      key_ff         <= key_in;
      op_ff          <= op_in;
      res_ff         <= res_in;
      status_ff      <= status_in;
      missing_ff     <= missing_in;
      rsp_max_xor_ff <= rsp_max_xor_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Allocator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff    <= NW'(KEY_BITS + 1);
         fresh_ff <= 1'b0;
      end else begin
         nf_ff    <= nf_in;
         fresh_ff <= fresh_in;
      end
   end

   assign st.stop = stop;
   assign st.fail = (status_ff != STAT_OK) || (op_ff == OP_ADD && pool_short);
   assign st.op   = op_ff;

   assign rsp_max_xor = rsp_max_xor_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

// ----- design/mmxq_ctrl.sv -----
// Controller of the multiset max-XOR query core: sequences the clearing pass,
// the check and update walks and the result handshake. Depends on mmxq_pkg.
`default_nettype none
`include "multiset_max_xor_query_core_macros.svh"

module mmxq_ctrl
   import mmxq_pkg::*;
#(
   parameter int KEY_BITS = 32,
   parameter int LW       = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_stat_type   st,
   output cmd_type            cmd,
   output logic [LW-1:0]      lvl
);

   ctl_state_type state_ff, state_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic          pass_ff, pass_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          two_pass;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign two_pass = (st.op == OP_ADD) || (st.op == OP_REMOVE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (lvl_ff == LW'(KEY_BITS)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_ROOT;
         end
         S_ROOT: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            if (st.stop || lvl_ff == '0) begin
               state_in = (two_pass && !pass_ff) ? S_FETCH : S_FINISH;
            end
         end
         S_FETCH: begin
            state_in = st.fail ? S_FINISH : S_ROOT;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Counters, pass flag and output word valid.
   always_comb begin
      lvl_in       = lvl_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR:  lvl_in = lvl_ff + LW'(1);
         S_IDLE:   pass_in = 1'b0;
         S_ROOT:   lvl_in = LW'(KEY_BITS - 1);
         S_WALK: begin
            if (lvl_ff != '0) lvl_in = lvl_ff - LW'(1);
         end
         S_FETCH:  pass_in = 1'b1;
         S_FINISH: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd          = '0;
      cmd.pass2    = pass_ff;
      cmd.clear    = (state_ff == S_CLEAR);
      cmd.capture  = (state_ff == S_IDLE) && req_valid;
      cmd.root     = (state_ff == S_ROOT);
      cmd.walk     = (state_ff == S_WALK);
      cmd.fetch    = (state_ff == S_FETCH);
      cmd.load_rsp = (state_ff == S_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         lvl_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign lvl       = lvl_ff;

   `MMXQ_ASSERT_IMP(a_walk_level, clock, reset, state_ff == S_WALK, lvl_ff < LW'(KEY_BITS), "walk level out of range")
   `MMXQ_ASSERT_NXT(a_accept_root, clock, reset, req_valid && req_ready, state_ff == S_ROOT, "accepted word did not start a walk")
   `MMXQ_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH, "result word raised outside finish")
   `MMXQ_ASSERT_IMP(a_pass2_op, clock, reset, state_ff == S_WALK && pass_ff, st.op == OP_ADD || st.op == OP_REMOVE, "update walk for an operation without updates")

endmodule

`default_nettype wire

// ----- design/multiset_max_xor_query_core.sv -----
// Sequence: a query walks from the root state to finish, where its result word is raised;
// an add or remove runs a check walk, a fetch and, if the check passes, an update walk;
// its check walk is shorter when it stops early. Words are taken one at a time; the next
// word is taken only after the result word of the last one has been raised.
// Reset: synchronous; a clearing pass then builds the zero path of nodes 0 to KEY_BITS.
// Depends on mmxq_pkg, mmxq_ctrl and mmxq_datapath.
`default_nettype none

module multiset_max_xor_query_core
   import mmxq_pkg::*;
#(
   parameter int KEY_BITS  = 32,
   parameter int NODE_POOL = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_key,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_max_xor,
   output logic [1:0]       rsp_status
);

   localparam int IW = $clog2(NODE_POOL);
   localparam int NW = $clog2(NODE_POOL + 1);
   localparam int LW = $clog2(KEY_BITS + 1);

   cmd_type       cmd;
   dp_stat_type   st;
   logic [LW-1:0] lvl;

   mmxq_ctrl #(
      .KEY_BITS (KEY_BITS),
      .LW       (LW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd),
      .lvl       (lvl)
   );

   mmxq_datapath #(
      .KEY_BITS  (KEY_BITS),
      .NODE_POOL (NODE_POOL),
      .IW        (IW),
      .NW        (NW),
      .LW        (LW)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .lvl           (lvl),
      .req_operation (req_operation),
      .req_key       (req_key),
      .st            (st),
      .rsp_max_xor   (rsp_max_xor),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the multiset max-XOR query core: directed table and random traffic.
// Depends on mmxq_pkg and multiset_max_xor_query_core; checks every result word in order.
`default_nettype none

module tb_top;
   import mmxq_pkg::*;

   localparam int KEY_BITS   = 32;
   localparam int NODE_POOL  = 65536;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 776;
   localparam int DRAIN_CYCLES = 2 * KEY_BITS + 16;
   localparam int CYCLE_LIMIT  = 500000;

   // One row of the directed table; typed rows carry a hand-written result.
   typedef struct {
      logic [1:0]  op;
      logic [31:0] key;
      bit          typed;
      logic [31:0] max_xor;
      logic [1:0]  status;
   } dir_row_type;

   typedef struct {
      logic [31:0] max_xor;
      logic [1:0]  status;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_ADD;
   logic [31:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_max_xor;
   logic [1:0]  rsp_status;

   // Shadow trie used to work out every result word.
   int unsigned trie_link [NODE_POOL][2];
   int unsigned trie_count [NODE_POOL];
   int unsigned trie_next_free;

   rsp_word_type pending_rsp [$];
   logic [31:0]  stored_keys [$];
   int           send_idle = 9;
   int           recv_idle = 51;
   int           mismatches = 0;
   int           checked = 0;
   int           full_seen = 0;
   int           cycles = 0;

   dir_row_type dir_rows [24] = '{
      '{OP_QUERY,  32'h0000_0000, 1, 32'h0000_0000, STAT_OK},
      '{OP_QUERY,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, STAT_OK},
      '{OP_REMOVE, 32'h0000_0000, 1, 32'h0000_0000, STAT_ABSENT},
      '{OP_REMOVE, 32'hFFFF_FFFF, 1, 32'h0000_0000, STAT_ABSENT},
      '{OP_UNUSED, 32'hFFFF_FFFF, 1, 32'h0000_0000, STAT_OK},
      '{OP_ADD,    32'hFFFF_FFFF, 1, 32'h0000_0000, STAT_OK},
      '{OP_QUERY,  32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_OK},
      '{OP_QUERY,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, STAT_OK},
      '{OP_ADD,    32'h0000_0000, 1, 32'h0000_0000, STAT_OK},
      '{OP_REMOVE, 32'h0000_0000, 1, 32'h0000_0000, STAT_OK},
      '{OP_REMOVE, 32'h0000_0000, 1, 32'h0000_0000, STAT_ABSENT},
      '{OP_REMOVE, 32'hFFFF_FFFF, 1, 32'h0000_0000, STAT_OK},
      '{OP_QUERY,  32'h0000_0000, 1, 32'h0000_0000, STAT_OK},
      '{OP_REMOVE, 32'hFFFF_FFFF, 1, 32'h0000_0000, STAT_ABSENT},
      '{OP_ADD,    32'h8000_0000, 0, '0, '0},
      '{OP_QUERY,  32'h7FFF_FFFF, 0, '0, '0},
      '{OP_ADD,    32'h0000_0001, 0, '0, '0},
      '{OP_QUERY,  32'h0000_0001, 0, '0, '0},
      '{OP_ADD,    32'h8000_0000, 0, '0, '0},
      '{OP_REMOVE, 32'h8000_0000, 0, '0, '0},
      '{OP_QUERY,  32'h0000_0000, 0, '0, '0},
      '{OP_REMOVE, 32'h8000_0001, 0, '0, '0},
      '{OP_QUERY,  32'h5555_AAAA, 0, '0, '0},
      '{OP_UNUSED, 32'h0000_0000, 0, '0, '0}
   };

   multiset_max_xor_query_core #(.KEY_BITS(KEY_BITS), .NODE_POOL(NODE_POOL)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_max_xor(rsp_max_xor), .rsp_status(rsp_status)
   );

   always #4 clock = ~clock;

   // Trie state after reset: only the permanent zero path.
   function automatic void trie_reset();
      for (int i = 0; i < NODE_POOL; i++) begin
         trie_link[i][0] = 0;
         trie_link[i][1] = 0;
         trie_count[i] = 0;
      end
      for (int i = 1; i <= KEY_BITS; i++) begin
         trie_link[i-1][0] = i;
         trie_count[i] = 1;
      end
      trie_next_free = KEY_BITS + 1;
   endfunction

   function automatic bit node_live(int unsigned node);
      return node != 0 && node < NODE_POOL && trie_count[node] != 0;
   endfunction

   // An add is refused whole when a count would overflow or the pool runs dry.
   function automatic logic [1:0] trie_add(logic [31:0] key);
      int unsigned node, c, missing;
      node = 0;
      missing = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         c = trie_link[node][key[lvl]];
         if (c == 0 || c >= NODE_POOL) begin
            missing = lvl + 1;
            break;
         end
         if (trie_count[c] >= COUNT_MAX) return STAT_FULL;
         node = c;
      end
      if (trie_next_free + missing > NODE_POOL) return STAT_FULL;
      node = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         c = trie_link[node][key[lvl]];
         if (c == 0 || c >= NODE_POOL) begin
            c = trie_next_free++;
            trie_link[c][0] = 0;
            trie_link[c][1] = 0;
            trie_count[c] = 0;
            trie_link[node][key[lvl]] = c;
         end
         trie_count[c]++;
         node = c;
      end
      return STAT_OK;
   endfunction

   // Zero needs a second copy before it can be removed.
   function automatic logic [1:0] trie_remove(logic [31:0] key);
      int unsigned node, c;
      node = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         c = trie_link[node][key[lvl]];
         if (!node_live(c)) return STAT_ABSENT;
         node = c;
      end
      if (trie_count[node] < (key == 0 ? 2 : 1)) return STAT_ABSENT;
      node = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         c = trie_link[node][key[lvl]];
         trie_count[c]--;
         node = c;
      end
      return STAT_OK;
   endfunction

   // Greedy walk toward the opposite bit at every level.
   function automatic logic [31:0] trie_query(logic [31:0] key);
      int unsigned node, opp, same;
      logic [31:0] best;
      node = 0;
      best = '0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         opp  = trie_link[node][!key[lvl]];
         same = trie_link[node][key[lvl]];
         if (node_live(opp)) begin
            best[lvl] = 1'b1;
            node = opp;
         end else if (node_live(same)) begin
            node = same;
         end else begin
            break;
         end
      end
      return best;
   endfunction

   function automatic rsp_word_type predict_word(logic [1:0] op, logic [31:0] key);
      rsp_word_type w;
      w.max_xor = '0;
      w.status = STAT_OK;
      case (op)
         OP_ADD: begin
            w.status = trie_add(key);
            if (w.status == STAT_OK) stored_keys.insert(stored_keys.size(), key);
            else full_seen++;
         end
         OP_REMOVE: begin
            w.status = trie_remove(key);
            if (w.status == STAT_OK) begin
               foreach (stored_keys[i]) begin
                  if (stored_keys[i] == key) begin
                     stored_keys.delete(i);
                     break;
                  end
               end
            end
         end
         OP_QUERY: w.max_xor = trie_query(key);
         default: ;
      endcase
      return w;
   endfunction

   // Send one word; entered and left at a falling edge. The expectation is
   // queued at the edge that accepts the word.
   task automatic send_word(logic [1:0] op, logic [31:0] key, bit typed,
                            rsp_word_type typed_rsp);
      rsp_word_type w;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key <= key;
      do @(posedge clock); while (!req_ready);
      w = predict_word(op, key);
      pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : w);
      @(negedge clock);
   endtask

   // Random key: the top bits only, a few low bits only, or fully random.
   function automatic logic [31:0] pick_key();
      case ($urandom_range(3))
         0: return {4'($urandom_range(15)), 28'h0};
         1: return $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Compare each result word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: max_xor=%h status=%0d", rsp_max_xor, rsp_status);
         end else begin
            e = pending_rsp.pop_front();
            checked++;
            if (rsp_max_xor !== e.max_xor || rsp_status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: expected max_xor=%h status=%0d, got max_xor=%h status=%0d",
                           checked, e.max_xor, e.status, rsp_max_xor, rsp_status);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      rsp_word_type typed_rsp;
      logic [1:0] op;
      logic [31:0] key;
      int pick;
      trie_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (dir_rows[i]) begin
         typed_rsp.max_xor = dir_rows[i].max_xor;
         typed_rsp.status  = dir_rows[i].status;
         send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, typed_rsp);
      end

      // Random traffic: adds, removes that mostly pick stored keys, queries and unused operations.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 3) begin
            send_idle = 51;
            recv_idle = 9;
         end else if (n == 2 * RANDOM_WORDS / 3) begin
            send_idle = 0;
            recv_idle = 0;
         end
         pick = $urandom_range(99);
         key = pick_key();
         if (pick < 40) begin
            op = OP_ADD;
            if (stored_keys.size() != 0 && $urandom_range(3) == 0)
               key = stored_keys[$urandom_range(stored_keys.size() - 1)];
         end else if (pick < 65) begin
            op = OP_REMOVE;
            if (stored_keys.size() != 0 && $urandom_range(4) != 0)
               key = stored_keys[$urandom_range(stored_keys.size() - 1)];
         end else if (pick < 95) begin
            op = OP_QUERY;
         end else begin
            op = OP_UNUSED;
         end
         send_word(op, key, 0, typed_rsp);
      end
      req_valid <= 1'b0;

      wait (pending_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d result words from the directed table and %0d random words",
               checked, RANDOM_WORDS);
      $display("Nodes in use at the end: %0d of %0d, refused adds: %0d",
               trie_next_free, NODE_POOL, full_seen);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/mmxq_pkg.sv
design/mmxq_datapath.sv
design/mmxq_ctrl.sv
design/multiset_max_xor_query_core.sv
sim/tb_top.sv
